/* rtl/core/nfac_pkg.sv */
// Shared types and constants for the next-fit allocator core.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package nfac_pkg;

    localparam logic [15:0] POOL_RESET = 16'd1000;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ASLOT,
        S_ASCAN,
        S_FRD,
        S_FCMP,
        S_FPOS,
        S_FLO,
        S_FACT,
        S_REMOVE,
        S_INSERT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] base;
        logic [16:0] len;
    } seg_ent_t;

    typedef struct packed {
        logic [15:0] ident;
        logic [15:0] base;
        logic [15:0] len;
    } proc_rec_t;

    typedef struct packed {
        logic wr;
        logic clr;
        logic clr_all;
    } proc_cmd_t;

endpackage

/* rtl/core/nfac_seg_table.sv */
// Address-sorted free-segment table: one read port, one write port, init of entry 0.
// Depends on nfac_pkg.
module nfac_seg_table #(
    parameter int FREE_SLOTS = 16,
    parameter int SIW        = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                init,
    input  logic [15:0]         init_len,
    input  logic [SIW-1:0]      rd_idx,
    output nfac_pkg::seg_ent_t  rd_ent,
    input  logic                wr_en,
    input  logic [SIW-1:0]      wr_idx,
    input  nfac_pkg::seg_ent_t  wr_ent
);

    nfac_pkg::seg_ent_t seg_reg [FREE_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg[0].base <= '0;
            seg_reg[0].len  <= {1'b0, nfac_pkg::POOL_RESET};
            for (int i = 1; i < FREE_SLOTS; i++)
            begin
                seg_reg[i] <= '0;
            end
        end
        else if (init)
        begin
            seg_reg[0].base <= '0;
            seg_reg[0].len  <= {1'b0, init_len};
        end
        else if (wr_en)
        begin
            seg_reg[wr_idx] <= wr_ent;
        end
    end

    assign rd_ent = seg_reg[rd_idx];

endmodule

/* rtl/core/nfac_proc_store.sv */
// Process records: valid bits in flip-flops, id/base/length in a memory with registered read.
// Depends on nfac_pkg.
module nfac_proc_store #(
    parameter int PROC_SLOTS = 64,
    parameter int PIW        = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nfac_pkg::proc_cmd_t cmd,
    input  logic [PIW-1:0]      addr,
    input  nfac_pkg::proc_rec_t wr_rec,
    output nfac_pkg::proc_rec_t rd_rec,
    output logic                valid_bit
);

    logic [PROC_SLOTS-1:0] valid_reg;
    nfac_pkg::proc_rec_t   rec_mem [PROC_SLOTS];
    nfac_pkg::proc_rec_t   rd_rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.clr_all)
        begin
            valid_reg <= '0;
        end
        else if (cmd.wr)
        begin
            valid_reg[addr] <= 1'b1;
        end
        else if (cmd.clr)
        begin
            valid_reg[addr] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            rec_mem[addr] <= wr_rec;
        end
        rd_rec_reg <= rec_mem[addr];
    end

    assign rd_rec    = rd_rec_reg;
    assign valid_bit = valid_reg[addr];

endmodule

/* rtl/core/next_fit_allocator_coalescing_core.sv */
// Next-fit pool allocator with coalescing free: sequencer and top level.
// Depends on nfac_pkg, nfac_seg_table and nfac_proc_store.
//
// Usage: one beat on the input channel (func, req_size, free_id) gives exactly one beat on
// the output channel (status, grant_addr, grant_id, seg_size); both use valid/ready.
// An allocate first walks the process slots one per cycle for a free record, then scans
// the free table from the rover one entry per cycle (up to FREE_SLOTS entries), and
// removes an emptied entry by shifting one entry per cycle.
// A free walks the process slots with a read state and a compare state per slot (registered
// memory read), finds the insertion point one entry per cycle, then merges, or inserts or
// removes by shifting.
// in_ready returns in the cycle in which out_valid rises. in_ready is high only while no
// item is in work; one finished result may wait in the output register while the next
// item is taken. When the receiver stalls, the block finishes the current item and then
// holds it until the output register is free.
// Reset sets the pool to 1000 units in one free segment, rover 0, no processes, id 0.
// A cfg_we write sets the pool size and reinitializes the same state; the user is to make
// it only while the block is idle, as the block itself does not enforce this.
module next_fit_allocator_coalescing_core #(
    parameter int FREE_SLOTS = 16,
    parameter int PROC_SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [15:0] req_size,
    input  logic [15:0] free_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] grant_addr,
    output logic [15:0] grant_id,
    output logic [15:0] seg_size,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int SIW = $clog2(FREE_SLOTS);
    localparam int CW  = $clog2(FREE_SLOTS + 1);
    localparam int PIW = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
    localparam logic [PIW-1:0] LAST_SLOT = PIW'(PROC_SLOTS - 1);
    localparam logic [CW-1:0]  FULL_CNT  = CW'(FREE_SLOTS);

    nfac_pkg::state_t state_reg, state_next;

    logic [15:0]     req_reg, req_next;
    logic [15:0]     fid_reg, fid_next;
    logic [PIW-1:0]  slot_reg, slot_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [SIW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [15:0]     a_reg, a_next;
    logic [15:0]     l_reg, l_next;
    logic            lo_join_reg, lo_join_next;
    logic [15:0]     lo_base_reg, lo_base_next;
    logic [16:0]     lo_len_reg, lo_len_next;
    logic            up_join_reg, up_join_next;
    logic [16:0]     up_len_reg, up_len_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [SIW-1:0]  rover_reg, rover_next;
    logic [15:0]     id_cnt_reg, id_cnt_next;
    logic [2:0]      res_status_reg, res_status_next;
    logic [15:0]     res_addr_reg, res_addr_next;
    logic [15:0]     res_id_reg, res_id_next;
    logic [15:0]     res_size_reg, res_size_next;
    logic            out_valid_reg, out_valid_next;
    logic [2:0]      status_reg, status_next;
    logic [15:0]     grant_addr_reg, grant_addr_next;
    logic [15:0]     grant_id_reg, grant_id_next;
    logic [15:0]     seg_size_reg, seg_size_next;

    logic [SIW-1:0]      seg_rd_idx;
    nfac_pkg::seg_ent_t  seg_rd;
    logic                seg_wr_en;
    logic [SIW-1:0]      seg_wr_idx;
    nfac_pkg::seg_ent_t  seg_wr;
    nfac_pkg::proc_cmd_t proc_cmd;
    nfac_pkg::proc_rec_t proc_wr;
    nfac_pkg::proc_rec_t proc_rd;
    logic                proc_valid;

    logic in_acc;
    logic out_free;
    logic pos_in;
    logic fit;
    logic lo_hit;
    logic up_hit;

    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign pos_in   = pos_reg < count_reg;
    assign fit      = seg_rd.len >= {1'b0, req_reg};
    assign lo_hit   = (pos_reg != '0) &&
                      (({2'b0, seg_rd.base} + {1'b0, seg_rd.len}) == {2'b0, a_reg});
    assign up_hit   = pos_in && (({1'b0, a_reg} + {1'b0, l_reg}) == {1'b0, seg_rd.base});

    nfac_seg_table #(
        .FREE_SLOTS (FREE_SLOTS),
        .SIW        (SIW)
    ) u_seg (
        .clk      (clk),
        .rst_n    (rst_n),
        .init     (cfg_we),
        .init_len (cfg_wdata),
        .rd_idx   (seg_rd_idx),
        .rd_ent   (seg_rd),
        .wr_en    (seg_wr_en),
        .wr_idx   (seg_wr_idx),
        .wr_ent   (seg_wr)
    );

    nfac_proc_store #(
        .PROC_SLOTS (PROC_SLOTS),
        .PIW        (PIW)
    ) u_proc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (proc_cmd),
        .addr      (slot_reg),
        .wr_rec    (proc_wr),
        .rd_rec    (proc_rd),
        .valid_bit (proc_valid)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfac_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (func == nfac_pkg::FUNC_FREE)
                        state_next = nfac_pkg::S_FRD;
                    else if (req_size == '0)
                        state_next = nfac_pkg::S_DONE;
                    else
                        state_next = nfac_pkg::S_ASLOT;
                end
            end
            nfac_pkg::S_ASLOT:
            begin
                if (!proc_valid)
                    state_next = nfac_pkg::S_ASCAN;
                else if (slot_reg == LAST_SLOT)
                    state_next = nfac_pkg::S_DONE;
            end
            nfac_pkg::S_ASCAN:
            begin
                if (k_reg == count_reg)
                    state_next = nfac_pkg::S_DONE;
                else if (fit)
                    state_next = (seg_rd.len == {1'b0, req_reg}) ? nfac_pkg::S_REMOVE
                                                                 : nfac_pkg::S_DONE;
            end
            nfac_pkg::S_FRD:
            begin
                state_next = nfac_pkg::S_FCMP;
            end
            nfac_pkg::S_FCMP:
            begin
                if (proc_valid && proc_rd.ident == fid_reg)
                    state_next = nfac_pkg::S_FPOS;
                else if (slot_reg == LAST_SLOT)
                    state_next = nfac_pkg::S_DONE;
                else
                    state_next = nfac_pkg::S_FRD;
            end
            nfac_pkg::S_FPOS:
            begin
                if (!(pos_in && seg_rd.base < a_reg))
                    state_next = nfac_pkg::S_FLO;
            end
            nfac_pkg::S_FLO:
            begin
                state_next = nfac_pkg::S_FACT;
            end
            nfac_pkg::S_FACT:
            begin
                if (lo_join_reg && up_join_reg)
                    state_next = nfac_pkg::S_REMOVE;
                else if (lo_join_reg || up_join_reg || count_reg == FULL_CNT)
                    state_next = nfac_pkg::S_DONE;
                else
                    state_next = nfac_pkg::S_INSERT;
            end
            nfac_pkg::S_REMOVE:
            begin
                if (!(k_reg + CW'(1) < count_reg))
                    state_next = nfac_pkg::S_DONE;
            end
            nfac_pkg::S_INSERT:
            begin
                if (!(k_reg > pos_reg))
                    state_next = nfac_pkg::S_DONE;
            end
            nfac_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = nfac_pkg::S_IDLE;
            end
            default:
            begin
                state_next = nfac_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        logic [SIW-1:0] r_tmp;
        logic [CW-1:0]  c_tmp;

        r_tmp           = rover_reg;
        c_tmp           = count_reg;
        in_ready        = (state_reg == nfac_pkg::S_IDLE);
        req_next        = req_reg;
        fid_next        = fid_reg;
        slot_next       = slot_reg;
        k_next          = k_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        a_next          = a_reg;
        l_next          = l_reg;
        lo_join_next    = lo_join_reg;
        lo_base_next    = lo_base_reg;
        lo_len_next     = lo_len_reg;
        up_join_next    = up_join_reg;
        up_len_next     = up_len_reg;
        count_next      = count_reg;
        rover_next      = rover_reg;
        id_cnt_next     = id_cnt_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_id_next     = res_id_reg;
        res_size_next   = res_size_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        grant_addr_next = grant_addr_reg;
        grant_id_next   = grant_id_reg;
        seg_size_next   = seg_size_reg;
        seg_rd_idx      = idx_reg;
        seg_wr_en       = 1'b0;
        seg_wr_idx      = idx_reg;
        seg_wr          = seg_rd;
        proc_cmd        = '0;
        proc_wr.ident   = id_cnt_reg;
        proc_wr.base    = seg_rd.base;
        proc_wr.len     = req_reg;

        case (state_reg)
            nfac_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    req_next        = req_size;
                    fid_next        = free_id;
                    slot_next       = '0;
                    res_status_next = nfac_pkg::ST_ZERO;
                    res_addr_next   = '0;
                    res_id_next     = '0;
                    res_size_next   = '0;
                end
            end
            nfac_pkg::S_ASLOT:
            begin
                if (!proc_valid)
                begin
                    k_next   = '0;
                    idx_next = (CW'(rover_reg) < count_reg) ? rover_reg : '0;
                end
                else if (slot_reg == LAST_SLOT)
                begin
                    res_status_next = nfac_pkg::ST_FULL;
                end
                else
                begin
                    slot_next = slot_reg + PIW'(1);
                end
            end
            nfac_pkg::S_ASCAN:
            begin
                if (k_reg == count_reg)
                begin
                    res_status_next = nfac_pkg::ST_NOFIT;
                end
                else if (fit)
                begin
                    // Cut from the low end and leave the rover on this entry.
                    seg_wr_en       = 1'b1;
                    seg_wr.base     = seg_rd.base + req_reg;
                    seg_wr.len      = seg_rd.len - {1'b0, req_reg};
                    rover_next      = idx_reg;
                    proc_cmd.wr     = 1'b1;
                    res_status_next = nfac_pkg::ST_OK;
                    res_addr_next   = seg_rd.base;
                    res_id_next     = id_cnt_reg;
                    res_size_next   = req_reg;
                    id_cnt_next     = id_cnt_reg + 16'd1;
                    pos_next        = CW'(idx_reg);
                    k_next          = CW'(idx_reg);
                end
                else
                begin
                    k_next   = k_reg + CW'(1);
                    idx_next = (CW'(idx_reg) + CW'(1) == count_reg) ? '0
                                                                    : idx_reg + SIW'(1);
                end
            end
            nfac_pkg::S_FCMP:
            begin
                if (proc_valid && proc_rd.ident == fid_reg)
                begin
                    a_next   = proc_rd.base;
                    l_next   = proc_rd.len;
                    pos_next = '0;
                end
                else if (slot_reg == LAST_SLOT)
                begin
                    res_status_next = nfac_pkg::ST_NOTFOUND;
                end
                else
                begin
                    slot_next = slot_reg + PIW'(1);
                end
            end
            nfac_pkg::S_FPOS:
            begin
                seg_rd_idx = pos_reg[SIW-1:0];
                if (pos_in && seg_rd.base < a_reg)
                begin
                    pos_next = pos_reg + CW'(1);
                end
                else
                begin
                    up_join_next = up_hit;
                    up_len_next  = seg_rd.len;
                end
            end
            nfac_pkg::S_FLO:
            begin
                seg_rd_idx   = SIW'(pos_reg - CW'(1));
                lo_join_next = lo_hit;
                lo_base_next = seg_rd.base;
                lo_len_next  = seg_rd.len;
            end
            nfac_pkg::S_FACT:
            begin
                res_status_next = nfac_pkg::ST_OK;
                res_addr_next   = a_reg;
                res_id_next     = fid_reg;
                res_size_next   = l_reg;
                proc_cmd.clr    = 1'b1;
                k_next          = pos_reg;
                if (lo_join_reg)
                begin
                    seg_wr_en   = 1'b1;
                    seg_wr_idx  = SIW'(pos_reg - CW'(1));
                    seg_wr.base = lo_base_reg;
                    seg_wr.len  = up_join_reg ? 17'(lo_len_reg + {1'b0, l_reg} + up_len_reg)
                                              : 17'(lo_len_reg + {1'b0, l_reg});
                end
                else if (up_join_reg)
                begin
                    seg_wr_en   = 1'b1;
                    seg_wr_idx  = pos_reg[SIW-1:0];
                    seg_wr.base = a_reg;
                    seg_wr.len  = 17'(up_len_reg + {1'b0, l_reg});
                end
                else if (count_reg == FULL_CNT)
                begin
                    // No room for a new entry: the process stays allocated.
                    proc_cmd.clr    = 1'b0;
                    res_status_next = nfac_pkg::ST_FULL;
                    res_addr_next   = '0;
                    res_id_next     = '0;
                    res_size_next   = '0;
                end
                else
                begin
                    k_next = count_reg;
                end
            end
            nfac_pkg::S_REMOVE:
            begin
                seg_rd_idx = SIW'(k_reg + CW'(1));
                if (k_reg + CW'(1) < count_reg)
                begin
                    seg_wr_en  = 1'b1;
                    seg_wr_idx = k_reg[SIW-1:0];
                    k_next     = k_reg + CW'(1);
                end
                else
                begin
                    c_tmp = count_reg - CW'(1);
                    if (pos_reg < CW'(rover_reg))
                        r_tmp = rover_reg - SIW'(1);
                    if (CW'(r_tmp) >= c_tmp)
                        r_tmp = '0;
                    count_next = c_tmp;
                    rover_next = r_tmp;
                end
            end
            nfac_pkg::S_INSERT:
            begin
                if (k_reg > pos_reg)
                begin
                    seg_rd_idx = SIW'(k_reg - CW'(1));
                    seg_wr_en  = 1'b1;
                    seg_wr_idx = k_reg[SIW-1:0];
                    k_next     = k_reg - CW'(1);
                end
                else
                begin
                    seg_wr_en   = 1'b1;
                    seg_wr_idx  = pos_reg[SIW-1:0];
                    seg_wr.base = a_reg;
                    seg_wr.len  = {1'b0, l_reg};
                    count_next  = count_reg + CW'(1);
                    if (count_reg == '0)
                        rover_next = '0;
                    else if (pos_reg <= CW'(rover_reg))
                        rover_next = rover_reg + SIW'(1);
                end
            end
            nfac_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    status_next     = res_status_reg;
                    grant_addr_next = res_addr_reg;
                    grant_id_next   = res_id_reg;
                    seg_size_next   = res_size_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            proc_cmd.clr_all = 1'b1;
            count_next       = (cfg_wdata != '0) ? CW'(1) : '0;
            rover_next       = '0;
            id_cnt_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfac_pkg::S_IDLE;
            count_reg     <= CW'(1);
            rover_reg     <= '0;
            id_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rover_reg     <= rover_next;
            id_cnt_reg    <= id_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        fid_reg        <= fid_next;
        slot_reg       <= slot_next;
        k_reg          <= k_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        a_reg          <= a_next;
        l_reg          <= l_next;
        lo_join_reg    <= lo_join_next;
        lo_base_reg    <= lo_base_next;
        lo_len_reg     <= lo_len_next;
        up_join_reg    <= up_join_next;
        up_len_reg     <= up_len_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_id_reg     <= res_id_next;
        res_size_reg   <= res_size_next;
        status_reg     <= status_next;
        grant_addr_reg <= grant_addr_next;
        grant_id_reg   <= grant_id_next;
        seg_size_reg   <= seg_size_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign grant_addr = grant_addr_reg;
    assign grant_id   = grant_id_reg;
    assign seg_size   = seg_size_reg;

endmodule

/* rtl/core/nfac_checker.sv */
// Port-level checks for the next-fit allocator core, bound to the top level.
// Depends on nfac_pkg and on next_fit_allocator_coalescing_core for the bind target.
module nfac_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [15:0] grant_addr,
    input logic [15:0] grant_id,
    input logic [15:0] seg_size
);

    // A result beat that is not taken stays valid with the same status and address.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(grant_addr))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= nfac_pkg::ST_ZERO)
        else $error("status code out of range");

    // A failed request reports no address, id or size.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != nfac_pkg::ST_OK |->
            grant_addr == '0 && grant_id == '0 && seg_size == '0)
        else $error("failed request carries payload");

    // The block takes one request at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while previous request in work");

endmodule

bind next_fit_allocator_coalescing_core nfac_checker u_nfac_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .grant_addr (grant_addr),
    .grant_id   (grant_id),
    .seg_size   (seg_size)
);

/* tb/sv/next_fit_allocator_coalescing_core_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for the next-fit allocator core: random and directed beats on both channels.
// Depends on nfac_pkg and next_fit_allocator_coalescing_core; it keeps its own allocator model.
module next_fit_allocator_coalescing_core_test;

    localparam int FREE_N = 16;
    localparam int PROC_N = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 200;

    typedef struct {
        logic [2:0]  st;
        logic [15:0] addr;
        logic [15:0] id;
        logic [15:0] size;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        func = nfac_pkg::FUNC_ALLOC;
    logic [15:0] req_size = '0;
    logic [15:0] free_id = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [15:0] grant_addr;
    logic [15:0] grant_id;
    logic [15:0] seg_size;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // Allocator model state.
    logic [15:0] hole_base [FREE_N];
    logic [16:0] hole_len [FREE_N];
    int          hole_count;
    int          rover;
    bit          owner_live [PROC_N];
    logic [15:0] owner_id [PROC_N];
    logic [15:0] owner_base [PROC_N];
    logic [15:0] owner_len [PROC_N];
    logic [15:0] next_id;

    grant_t pending_grants[$];
    bit     idle_on = 1'b1;
    int     mismatches = 0;
    int     beats_sent = 0;
    int     beats_seen = 0;
    int     pool_writes = 0;
    int     cycles = 0;

    next_fit_allocator_coalescing_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .req_size(req_size), .free_id(free_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .grant_addr(grant_addr), .grant_id(grant_id), .seg_size(seg_size),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic void reset_pool(logic [15:0] units);
        for (int i = 0; i < FREE_N; i++)
        begin
            hole_base[i] = '0;
            hole_len[i] = '0;
        end
        hole_count = (units == 0) ? 0 : 1;
        hole_len[0] = {1'b0, units};
        rover = 0;
        for (int i = 0; i < PROC_N; i++)
            owner_live[i] = 1'b0;
        next_id = '0;
    endfunction

    function automatic void drop_hole(int i);
        for (int k = i; k + 1 < hole_count; k++)
        begin
            hole_base[k] = hole_base[k + 1];
            hole_len[k] = hole_len[k + 1];
        end
        hole_count--;
        if (i < rover)
            rover--;
        if (rover >= hole_count)
            rover = 0;
    endfunction

    function automatic grant_t allocate_units(logic [15:0] req);
        grant_t g;
        int slot;
        int start;
        int i;
        g = '{nfac_pkg::ST_NOFIT, 16'd0, 16'd0, 16'd0};
        if (req == 0)
        begin
            g.st = nfac_pkg::ST_ZERO;
            return g;
        end
        slot = PROC_N;
        for (int s = PROC_N - 1; s >= 0; s--)
            if (!owner_live[s])
                slot = s;
        if (slot == PROC_N)
        begin
            g.st = nfac_pkg::ST_FULL;
            return g;
        end
        start = (rover < hole_count) ? rover : 0;
        for (int k = 0; k < hole_count; k++)
        begin
            i = start + k;
            if (i >= hole_count)
                i -= hole_count;
            if (hole_len[i] >= req)
            begin
                g = '{nfac_pkg::ST_OK, hole_base[i], next_id, req};
                hole_base[i] = hole_base[i] + req;
                hole_len[i] = hole_len[i] - req;
                rover = i;
                if (hole_len[i] == 0)
                    drop_hole(i);
                owner_live[slot] = 1'b1;
                owner_id[slot] = next_id;
                owner_base[slot] = g.addr;
                owner_len[slot] = req;
                next_id = next_id + 16'd1;
                return g;
            end
        end
        return g;
    endfunction

    function automatic grant_t release_id(logic [15:0] id);
        grant_t g;
        int slot;
        int pos;
        int a;
        int l;
        bit join_lo;
        bit join_up;
        g = '{nfac_pkg::ST_NOTFOUND, 16'd0, 16'd0, 16'd0};
        slot = PROC_N;
        for (int s = PROC_N - 1; s >= 0; s--)
            if (owner_live[s] && owner_id[s] == id)
                slot = s;
        if (slot == PROC_N)
            return g;
        a = owner_base[slot];
        l = owner_len[slot];
        pos = 0;
        while (pos < hole_count && int'(hole_base[pos]) < a)
            pos++;
        join_lo = pos > 0 && int'(hole_base[pos - 1]) + int'(hole_len[pos - 1]) == a;
        join_up = pos < hole_count && a + l == int'(hole_base[pos]);
        if (join_lo && join_up)
        begin
            hole_len[pos - 1] = hole_len[pos - 1] + l + hole_len[pos];
            drop_hole(pos);
        end
        else if (join_lo)
            hole_len[pos - 1] = hole_len[pos - 1] + l;
        else if (join_up)
        begin
            hole_base[pos] = a;
            hole_len[pos] = hole_len[pos] + l;
        end
        else
        begin
            if (hole_count >= FREE_N)
            begin
                g.st = nfac_pkg::ST_FULL;
                return g;
            end
            for (int k = hole_count; k > pos; k--)
            begin
                hole_base[k] = hole_base[k - 1];
                hole_len[k] = hole_len[k - 1];
            end
            hole_base[pos] = a;
            hole_len[pos] = l;
            if (hole_count == 0)
                rover = 0;
            else if (pos <= rover)
                rover++;
            hole_count++;
        end
        owner_live[slot] = 1'b0;
        g = '{nfac_pkg::ST_OK, a[15:0], id, l[15:0]};
        return g;
    endfunction

    // Sends one beat; valid stays high across back-to-back beats.
    task automatic send_item(logic f, logic [15:0] req, logic [15:0] id);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        req_size <= req;
        free_id <= id;
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
        pending_grants.push_back(f == nfac_pkg::FUNC_ALLOC ? allocate_units(req)
                                                           : release_id(id));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_pool(logic [15:0] units);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= units;
        @(posedge clk);
        cfg_we <= 1'b0;
        reset_pool(units);
        pool_writes++;
    endtask

    function automatic logic [15:0] pick_live_id();
        logic [15:0] ids[$];
        for (int s = 0; s < PROC_N; s++)
            if (owner_live[s])
                ids.push_back(owner_id[s]);
        if (ids.size() == 0)
            return 16'($urandom);
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    task automatic test_field_extremes();
        send_item(nfac_pkg::FUNC_ALLOC, 16'd0, 16'hFFFF);
        send_item(nfac_pkg::FUNC_FREE, 16'hFFFF, 16'hFFFF);
        send_item(nfac_pkg::FUNC_ALLOC, 16'd1000, 16'd0);
        send_item(nfac_pkg::FUNC_ALLOC, 16'd1, 16'd0);
        send_item(nfac_pkg::FUNC_FREE, 16'd0, 16'd0);
        send_item(nfac_pkg::FUNC_ALLOC, 16'd300, 16'd0);
        send_item(nfac_pkg::FUNC_ALLOC, 16'd200, 16'd0);
        send_item(nfac_pkg::FUNC_ALLOC, 16'd100, 16'd0);
        // Freeing the middle one first, then its neighbors, covers no merge, a merge on both sides and an upper merge.
        send_item(nfac_pkg::FUNC_FREE, 16'd0, 16'd2);
        send_item(nfac_pkg::FUNC_FREE, 16'd0, 16'd3);
        send_item(nfac_pkg::FUNC_FREE, 16'd0, 16'd1);
        send_item(nfac_pkg::FUNC_ALLOC, 16'hFFFF, 16'd0);
    endtask

    task automatic test_big_and_empty_pool();
        write_pool(16'hFFFF);
        send_item(nfac_pkg::FUNC_ALLOC, 16'hFFFF, 16'h5A5A);
        send_item(nfac_pkg::FUNC_ALLOC, 16'd1, 16'd0);
        send_item(nfac_pkg::FUNC_FREE, 16'd0, 16'd0);
        send_item(nfac_pkg::FUNC_ALLOC, 16'h8000, 16'd0);
        write_pool(16'd0);
        send_item(nfac_pkg::FUNC_ALLOC, 16'd1, 16'd0);
        send_item(nfac_pkg::FUNC_FREE, 16'd0, 16'd0);
    endtask

    task automatic test_table_limits();
        write_pool(16'd200);
        for (int i = 0; i < PROC_N + 1; i++)
            send_item(nfac_pkg::FUNC_ALLOC, 16'd2, 16'd0);
        // Releasing every other process leaves an isolated hole each time until the free table overflows.
        for (int i = 0; i < 2 * FREE_N + 2; i += 2)
            send_item(nfac_pkg::FUNC_FREE, 16'd0, 16'(i));
    endtask

    task automatic test_random(logic [15:0] units, int count);
        int r;
        logic [15:0] req;
        write_pool(units);
        for (int n = 0; n < count; n++)
        begin
            if (n == count - 40)
                idle_on = 1'b0;
            if (n == count / 2)
                wait_idle();
            r = $urandom_range(0, 99);
            if (r < 40)
                send_item(nfac_pkg::FUNC_FREE, 16'($urandom), pick_live_id());
            else if (r < 45)
                send_item(nfac_pkg::FUNC_FREE, 16'($urandom), 16'($urandom));
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    req = '0;
                else if (r < 15)
                    req = 16'($urandom);
                else
                    req = 16'($urandom_range(1, (units > 16) ? units / 8 : 2));
                send_item(nfac_pkg::FUNC_ALLOC, req, 16'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    // Receiver side: random stalls while idling is on.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen++;
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d addr %0d id %0d size %0d",
                             status, grant_addr, grant_id, seg_size);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (status !== want.st || grant_addr !== want.addr ||
                    grant_id !== want.id || seg_size !== want.size)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 beats_seen, want.st, want.addr, want.id, want.size,
                                 status, grant_addr, grant_id, seg_size);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("next_fit_allocator_coalescing_core_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        reset_pool(nfac_pkg::POOL_RESET);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_big_and_empty_pool();
        test_table_limits();
        test_random(16'd1000, 100);
        test_random(16'd1, 40);
        test_random(16'd300, 80);
        test_random(16'hFFFF, 80);
        wait_idle();
        $display("%0d request beats and %0d result beats over %0d pool sizes,",
                 beats_sent, beats_seen, pool_writes + 1);
        $display("including merges, full tables, zero sizes and unknown ids.");
        if (mismatches == 0)
            $display("next_fit_allocator_coalescing_core_test: done, clean");
        else
            $display("next_fit_allocator_coalescing_core_test: done, errors");
        $finish;
    end

endmodule
